>>> hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define CHK_ALWAYS(label, clk, rst_n, expr, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/lfra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfra_pkg;

    localparam int TIME_IN_W = 32;
    localparam int TAG_W     = 16;
    localparam int ROOM_W    = 7;

    typedef struct packed {
        logic release_en;
        logic grant_en;
    } lfra_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/lfra_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lfra_cell #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lfra_pkg::lfra_ctl_t    ctl,
    input  wire logic [TIME_BITS-1:0]   arrival,
    input  wire logic [TIME_BITS-1:0]   departure,
    input  wire logic                   claim_in,
    output logic                        claim_out,
    output logic                        granted
);

    logic                 busy_reg;
    logic                 busy_next;
    logic [TIME_BITS-1:0] release_reg;
    logic [TIME_BITS-1:0] release_next;

    assign granted   = claim_in & ~busy_reg;
    assign claim_out = claim_in & busy_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        release_next = release_reg;
        if (ctl.release_en && busy_reg && (release_reg < arrival))
        begin
            busy_next = 1'b0;
        end
        if (ctl.grant_en && granted)
        begin
            busy_next    = 1'b1;
            release_next = departure;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        release_reg <= release_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/lfra_encoder.sv
`timescale 1ns / 1ps
`default_nettype none

module lfra_encoder #(
    parameter int NUM_ROOMS = 64
) (
    input  wire logic [NUM_ROOMS-1:0]           grant_vec,
    output logic                                found,
    output logic [$clog2(NUM_ROOMS+1)-1:0]      index
);

    localparam int ROOM_BITS = $clog2(NUM_ROOMS + 1);

    // one-hot to binary, or of the indexes of the set bits
    always_comb
    begin
        index = '0;
        for (int i = 0; i < NUM_ROOMS; i++)
        begin
            if (grant_vec[i])
            begin
                index = index | ROOM_BITS'(i);
            end
        end
    end

    assign found = |grant_vec;

endmodule

`default_nettype wire

>>> hw/rtl/lowest_free_room_allocator_core.sv
// an accepted input word is registered, then passes the release step and the grant step,
// which writes the result word; a new word waits until idle or until a result is written
// the release compare runs in every room cell at once, then a claim chain through the cells
// picks the lowest free room; a stalled output holds the grant step until it drains
// async reset (rst_n low) frees all rooms, clears the used count; release times are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lowest_free_room_allocator_core #(
    parameter int NUM_ROOMS = 64,
    parameter int TIME_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [lfra_pkg::TIME_IN_W-1:0]     arrival,
    input  wire logic [lfra_pkg::TIME_IN_W-1:0]     departure,
    input  wire logic [lfra_pkg::TAG_W-1:0]         tag,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [lfra_pkg::TAG_W-1:0]              tag_out,
    output logic [lfra_pkg::ROOM_W-1:0]             room,
    output logic [lfra_pkg::ROOM_W-1:0]             rooms_used,
    output logic                                    no_room
);

    localparam int ROOM_BITS = $clog2(NUM_ROOMS + 1);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_RELEASE = 2'd1;
    localparam logic [1:0] PH_GRANT   = 2'd2;

    logic [1:0]                    phase_reg;
    logic [1:0]                    phase_next;
    logic [TIME_BITS-1:0]          arr_reg;
    logic [TIME_BITS-1:0]          dep_reg;
    logic [lfra_pkg::TAG_W-1:0]    tag_reg;
    logic [ROOM_BITS-1:0]          highest_used_reg;
    logic [ROOM_BITS-1:0]          highest_used_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [lfra_pkg::TAG_W-1:0]    tag_out_reg;
    logic [lfra_pkg::ROOM_W-1:0]   room_reg;
    logic [lfra_pkg::ROOM_W-1:0]   rooms_used_reg;
    logic                          no_room_reg;

    lfra_pkg::lfra_ctl_t           ctl;
    logic [NUM_ROOMS:0]            claim;
    logic [NUM_ROOMS-1:0]          grant_vec;
    logic                          found;
    logic [ROOM_BITS-1:0]          pick_index;
    logic [ROOM_BITS-1:0]          pick_room;
    logic                          can_write;
    logic                          commit;
    logic                          in_accept;

    assign can_write = ~out_valid_reg | ~out_stall;
    assign commit    = (phase_reg == PH_GRANT) && can_write;
    assign in_stall  = ~((phase_reg == PH_IDLE) || commit);
    assign in_accept = in_valid & ~in_stall;

    assign ctl.release_en = (phase_reg == PH_RELEASE);
    assign ctl.grant_en   = commit;

    // room cells, claim token ripples from room 1 upward
    assign claim[0] = 1'b1;

    for (genvar g = 0; g < NUM_ROOMS; g++)
    begin : g_cell
        lfra_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .arrival   (arr_reg),
            .departure (dep_reg),
            .claim_in  (claim[g]),
            .claim_out (claim[g+1]),
            .granted   (grant_vec[g])
        );
    end

    lfra_encoder #(
        .NUM_ROOMS (NUM_ROOMS)
    ) u_encoder (
        .grant_vec (grant_vec),
        .found     (found),
        .index     (pick_index)
    );

    assign pick_room = pick_index + ROOM_BITS'(1);

    always_comb
    begin
        highest_used_next = highest_used_reg;
        if (commit && found && (pick_room > highest_used_reg))
        begin
            highest_used_next = pick_room;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        priority if (in_accept)
        begin
            phase_next = PH_RELEASE;
        end
        else if (phase_reg == PH_RELEASE)
        begin
            phase_next = PH_GRANT;
        end
        else if (commit)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            highest_used_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            highest_used_reg <= highest_used_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // input word and result word payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            arr_reg <= TIME_BITS'(arrival);
            dep_reg <= TIME_BITS'(departure);
            tag_reg <= tag;
        end
        if (commit)
        begin
            tag_out_reg    <= tag_reg;
            room_reg       <= found ? lfra_pkg::ROOM_W'(pick_room) : '0;
            rooms_used_reg <= lfra_pkg::ROOM_W'(highest_used_next);
            no_room_reg    <= ~found;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tag_out    = tag_out_reg;
    assign room       = room_reg;
    assign rooms_used = rooms_used_reg;
    assign no_room    = no_room_reg;

    `CHK_ALWAYS(a_grant_onehot, clk, rst_n, $onehot0(grant_vec), "more than one room granted")
    `CHK_IMPLY(a_refused_room_zero, clk, rst_n, out_valid && no_room, room == '0, "refused word has a room")
    `CHK_ALWAYS(a_used_monotonic, clk, rst_n, highest_used_reg >= $past(highest_used_reg), "rooms_used fell")
    `CHK_IMPLY(a_no_accept_busy, clk, rst_n, phase_reg == PH_RELEASE, in_stall && !commit, "accept during release")

endmodule

`default_nettype wire

>>> dv/tb_lowest_free_room_allocator_core.sv
`timescale 1ns / 1ps

module tb_lowest_free_room_allocator_core;

    localparam int ROOMS = 64;
    localparam int STAY_COUNT = 1650;
    localparam longint unsigned T_MAX = 64'hFFFF_FFFF;

    typedef struct {
        logic [lfra_pkg::TIME_IN_W-1:0] arrival;
        logic [lfra_pkg::TIME_IN_W-1:0] departure;
        logic [lfra_pkg::TAG_W-1:0]     tag;
        int                             gap;
        bit                             drain;
    } stay_req_t;

    typedef struct {
        logic [lfra_pkg::TAG_W-1:0]  tag;
        logic [lfra_pkg::ROOM_W-1:0] room;
        logic [lfra_pkg::ROOM_W-1:0] rooms_used;
        logic                        no_room;
    } room_grant_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [lfra_pkg::TIME_IN_W-1:0] arrival = '0;
    logic [lfra_pkg::TIME_IN_W-1:0] departure = '0;
    logic [lfra_pkg::TAG_W-1:0]     tag = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [lfra_pkg::TAG_W-1:0]     tag_out;
    logic [lfra_pkg::ROOM_W-1:0]    room;
    logic [lfra_pkg::ROOM_W-1:0]    rooms_used;
    logic                           no_room;

    stay_req_t   stay_queue[$];
    room_grant_t grants_due[$];
    stay_req_t   cur;
    bit          have_cur = 1'b0;
    int          gap_left = 0;
    bit          word_taken = 1'b0;
    bit          failed = 1'b0;
    int          results_seen = 0;
    int          refused_seen = 0;
    int          top_room_seen = 0;
    int          fills_made = 0;
    int          stays_made = 0;

    // allocator state mirror
    bit                             busy_map[ROOMS];
    logic [lfra_pkg::TIME_IN_W-1:0] release_at[ROOMS];
    int                             top_room = 0;

    int hold_left = 0;
    int next_hold_at = 300;
    int calm_left = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    lowest_free_room_allocator_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .arrival    (arrival),
        .departure  (departure),
        .tag        (tag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tag_out    (tag_out),
        .room       (room),
        .rooms_used (rooms_used),
        .no_room    (no_room)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic room_grant_t assign_room(stay_req_t s);
        room_grant_t g;
        int pick;
        pick = -1;
        for (int r = 0; r < ROOMS; r++)
        begin
            if (busy_map[r] && release_at[r] < s.arrival)
                busy_map[r] = 1'b0;
        end
        for (int r = 0; r < ROOMS; r++)
        begin
            if (!busy_map[r] && pick < 0)
                pick = r;
        end
        g.tag = s.tag;
        g.no_room = (pick < 0);
        g.room = '0;
        if (pick >= 0)
        begin
            busy_map[pick] = 1'b1;
            release_at[pick] = s.departure;
            if (pick + 1 > top_room)
                top_room = pick + 1;
            g.room = lfra_pkg::ROOM_W'(pick + 1);
        end
        g.rooms_used = lfra_pkg::ROOM_W'(top_room);
        return g;
    endfunction

    // mostly back to back, a few long gaps
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic void add_stay(longint unsigned a, longint unsigned d,
                                     int unsigned id, int gap, bit drain);
        stay_req_t s;
        s.arrival = lfra_pkg::TIME_IN_W'(a);
        s.departure = lfra_pkg::TIME_IN_W'(d);
        s.tag = lfra_pkg::TAG_W'(id);
        s.gap = gap;
        s.drain = drain;
        stay_queue.push_back(s);
        stays_made++;
    endfunction

    task automatic make_random_stays();
        longint unsigned t;
        longint unsigned a;
        longint unsigned hi;
        int made;
        int s;
        int k;
        bit quiet;
        t = 10;
        made = 1;
        add_stay(t, t + 2, $urandom, 0, 1'b1);
        while (made < STAY_COUNT)
        begin
            s = $urandom_range(0, 99);
            quiet = ($urandom_range(0, 4) == 0);
            if (t >= 64'hF000_0000 || (s >= 83 && s < 85))
            begin
                // latest possible arrival, then time starts over low
                add_stay(T_MAX, 64'($urandom_range(0, 200)), $urandom, pick_gap(quiet), 1'b1);
                t = 64'($urandom_range(0, 100));
                made++;
            end
            else if (s < 55)
            begin
                k = $urandom_range(1, 8);
                repeat (k)
                begin
                    t += 64'($urandom_range(0, 3));
                    if ($urandom_range(0, 4) != 0)
                        add_stay(t, t + 64'($urandom_range(0, 40)), $urandom,
                                 pick_gap(quiet), 1'b0);
                    else
                        add_stay(t, t + 64'($urandom_range(41, 3000)), $urandom,
                                 pick_gap(quiet), 1'b0);
                    made++;
                end
            end
            else if (s < 65)
            begin
                // departure at or before arrival
                t += 64'($urandom_range(0, 2));
                a = (t < 100) ? t : 100;
                add_stay(t, t - 64'($urandom_range(0, 32'(a))), $urandom,
                         pick_gap(quiet), 1'b0);
                made++;
            end
            else if (s < 72)
            begin
                // arrival out of order
                a = (t < 50) ? t : 50;
                a = t - 64'($urandom_range(0, 32'(a)));
                add_stay(a, a + 64'($urandom_range(0, 20)), $urandom, pick_gap(quiet), 1'b0);
                made++;
            end
            else if (s < 80)
            begin
                hi = 64'hF000_0000 - t;
                if (hi > 64'h3FFF_FFFF)
                    hi = 64'h3FFF_FFFF;
                t += 64'($urandom_range(1000, 32'(hi)));
                add_stay(t, t + 64'($urandom_range(0, 100)), $urandom, pick_gap(quiet), 1'b0);
                made++;
            end
            else if (s < 83)
            begin
                // more requests than rooms at one arrival
                k = $urandom_range(66, 70);
                repeat (k)
                begin
                    add_stay(t, t + 64'($urandom_range(100, 2000)), $urandom,
                             pick_gap(quiet), 1'b0);
                    made++;
                end
                fills_made++;
                t += 64'($urandom_range(500, 2500));
            end
            else
            begin
                t += 64'($urandom_range(0, 5));
                add_stay(t, t + 64'($urandom_range(0, 10)), $urandom, pick_gap(quiet), 1'b0);
                made++;
            end
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            if (word_taken)
            begin
                nxt_valid = 1'b0;
                have_cur = 1'b0;
            end
            if (!have_cur && stay_queue.size() != 0)
            begin
                cur = stay_queue.pop_front();
                have_cur = 1'b1;
                gap_left = cur.gap;
            end
            if (have_cur && !nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (!(cur.drain && grants_due.size() != 0))
                begin
                    nxt_valid = 1'b1;
                    arrival <= cur.arrival;
                    departure <= cur.departure;
                    tag <= cur.tag;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (calm_left == 0)
            begin
                calm_left = $urandom_range(50, 300);
                calm = ($urandom_range(0, 3) == 0);
            end
            else
                calm_left--;
            if (hold_left == 0 && results_seen >= next_hold_at)
            begin
                hold_left = $urandom_range(120, 200);
                next_hold_at += 700;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
            begin
                stall_left = pick_gap(1'b0);
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch
        stay_req_t   got;
        room_grant_t want;
        if (rst_n)
        begin
            word_taken = in_valid && !in_stall;
            if (word_taken)
            begin
                got.arrival = arrival;
                got.departure = departure;
                got.tag = tag;
                got.gap = 0;
                got.drain = 1'b0;
                grants_due.push_back(assign_room(got));
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (no_room === 1'b1)
                    refused_seen++;
                if (int'(room) > top_room_seen)
                    top_room_seen = int'(room);
                if (grants_due.size() == 0)
                begin
                    $error("unexpected result word: tag_out %0h room %0d", tag_out, room);
                    failed = 1'b1;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (tag_out !== want.tag)
                    begin
                        $error("tag_out expected %0h actual %0h", want.tag, tag_out);
                        failed = 1'b1;
                    end
                    if (room !== want.room)
                    begin
                        $error("room expected %0d actual %0d", want.room, room);
                        failed = 1'b1;
                    end
                    if (rooms_used !== want.rooms_used)
                    begin
                        $error("rooms_used expected %0d actual %0d", want.rooms_used, rooms_used);
                        failed = 1'b1;
                    end
                    if (no_room !== want.no_room)
                    begin
                        $error("no_room expected %0b actual %0b", want.no_room, no_room);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        add_stay('0, '0, '0, 0, 1'b0);
        add_stay('0, 5, 'hFFFF, 0, 1'b0);
        add_stay(1, 1, 'h0001, 1, 1'b0);
        add_stay(1, 1, 'h8000, 0, 1'b0);
        add_stay(2, '0, 'h7FFF, 0, 1'b0);
        add_stay(1, 3, 'h1234, 2, 1'b0);
        add_stay(2, T_MAX, 'hAAAA, 0, 1'b0);
        add_stay(5, 5, 'h5555, 0, 1'b0);
        add_stay(5, 64'h8000_0000, 'hC3C3, 0, 1'b0);
        add_stay(64'h8000_0001, 64'hFFFF_FFFE, 'h3C3C, 3, 1'b0);
        add_stay(T_MAX, 3, 'h5A5A, 0, 1'b0);
        add_stay(T_MAX, 64'h7FFF_FFFF, 'hA5A5, 0, 1'b0);
        make_random_stays();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (stay_queue.size() != 0 || have_cur)
            @(posedge clk);
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d stay requests, %0d results, %0d refused with every room busy",
                 stays_made, results_seen, refused_seen);
        $display("%0d overbooked bursts, highest room granted %0d", fills_made, top_room_seen);
        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/lfra_pkg.sv
hw/rtl/lfra_cell.sv
hw/rtl/lfra_encoder.sv
hw/rtl/lowest_free_room_allocator_core.sv
dv/tb_lowest_free_room_allocator_core.sv
